FILE: design/twist_magnitude_limiter_top_assert.svh
// Assertion macros shared by the twist magnitude limiter checker.
`ifndef TWIST_MAGNITUDE_LIMITER_TOP_ASSERT_SVH
`define TWIST_MAGNITUDE_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TML_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tml checker: property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TML_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tml checker: property failed");

`endif

FILE: design/tml_pkg.sv
// Shared types, constants and step functions of the twist magnitude limiter.
package tml_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int SUM_W      = 2 * DATA_WIDTH;
    localparam int REM_W      = DATA_WIDTH + 2;
    localparam int SQRT_STEPS = DATA_WIDTH;
    localparam int DIV_STEPS  = DATA_WIDTH;
    localparam int PADDR_W    = 3;

    localparam logic [DATA_WIDTH-1:0] LIMIT_RESET = DATA_WIDTH'(65536);

    // Register select bit of paddr
    localparam logic REG_LIN = 1'b0;
    localparam logic REG_ANG = 1'b1;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        word_t [2:0] lin;
        word_t [2:0] ang;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  neg;
        word_t [2:0] mag;
    } vec_t;

    typedef struct packed {
        vec_t                  lin;
        vec_t                  ang;
        logic [2:0][SUM_W-1:0] lin_sq;
        logic [2:0][SUM_W-1:0] ang_sq;
    } sq_t;

    typedef struct packed {
        vec_t             lin;
        vec_t             ang;
        logic [SUM_W-1:0] lin_sum;
        logic [SUM_W-1:0] ang_sum;
    } sum_t;

    typedef struct packed {
        logic [SUM_W-1:0] rad;
        logic [REM_W-1:0] rem;
        word_t            root;
    } sqrt_lane_t;

    typedef struct packed {
        vec_t       lin;
        vec_t       ang;
        sqrt_lane_t lin_s;
        sqrt_lane_t ang_s;
    } sqrt_stage_t;

    typedef struct packed {
        vec_t  lin;
        vec_t  ang;
        word_t lin_norm;
        word_t ang_norm;
    } norm_t;

    typedef struct packed {
        word_t lo;
        word_t rem;
        word_t q;
    } div_lane_t;

    typedef struct packed {
        vec_t             lin;
        vec_t             ang;
        word_t            lin_norm;
        word_t            ang_norm;
        logic             lin_lim;
        logic             ang_lim;
        div_lane_t [2:0]  lin_d;
        div_lane_t [2:0]  ang_d;
    } div_stage_t;

    typedef struct packed {
        word_t [2:0] lin;
        word_t [2:0] ang;
        logic        lin_lim;
        logic        ang_lim;
    } res_t;

    // One digit of the shift-subtract square root: two radicand bits in.
    function automatic sqrt_lane_t sqrt_step(sqrt_lane_t s);
        sqrt_lane_t       r;
        logic [REM_W:0]   t;
        logic [REM_W:0]   trial;
        t     = {s.rem[REM_W-2:0], s.rad[SUM_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        r.rad = {s.rad[SUM_W-3:0], 2'b00};
        if (t >= trial)
        begin
            r.rem  = REM_W'(t - trial);
            r.root = {s.root[DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            r.rem  = t[REM_W-1:0];
            r.root = {s.root[DATA_WIDTH-2:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of restoring division; rem stays below d once it starts below d.
    function automatic div_lane_t div_step(div_lane_t s, word_t d);
        div_lane_t             r;
        logic [DATA_WIDTH:0]   t;
        t    = {s.rem, s.lo[DATA_WIDTH-1]};
        r.lo = {s.lo[DATA_WIDTH-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            r.rem = DATA_WIDTH'(t - {1'b0, d});
            r.q   = {s.q[DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[DATA_WIDTH-1:0];
            r.q   = {s.q[DATA_WIDTH-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: design/tml_cmd_if.sv
// Command channel: one six-component velocity word.
interface tml_cmd_if import tml_pkg::*;
    ();
    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  lin_x;
    logic signed [DATA_WIDTH-1:0]  lin_y;
    logic signed [DATA_WIDTH-1:0]  lin_z;
    logic signed [DATA_WIDTH-1:0]  ang_x;
    logic signed [DATA_WIDTH-1:0]  ang_y;
    logic signed [DATA_WIDTH-1:0]  ang_z;

    modport source (output valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, input ready);
    modport sink   (input valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, output ready);
endinterface

FILE: design/tml_rsp_if.sv
// Result channel: one limited velocity word with its two flags.
interface tml_rsp_if import tml_pkg::*;
    ();
    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  out_lin_x;
    logic signed [DATA_WIDTH-1:0]  out_lin_y;
    logic signed [DATA_WIDTH-1:0]  out_lin_z;
    logic signed [DATA_WIDTH-1:0]  out_ang_x;
    logic signed [DATA_WIDTH-1:0]  out_ang_y;
    logic signed [DATA_WIDTH-1:0]  out_ang_z;
    logic                          linear_limited;
    logic                          angular_limited;

    modport source (output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                    out_ang_z, linear_limited, angular_limited, input ready);
    modport sink   (input valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                    out_ang_z, linear_limited, angular_limited, output ready);
endinterface

FILE: design/tml_front.sv
// Front end: component magnitudes, squares, then sums of squares.
module tml_front import tml_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output sum_t out_data
);

    logic [1:0] vld_reg;
    logic [1:0] adv;
    sq_t        sq_reg;
    sq_t        sq_next;
    sum_t       sum_reg;
    sum_t       sum_next;

    function automatic vec_t make_vec(word_t [2:0] v);
        vec_t r;
        for (int k = 0; k < 3; k++)
        begin
            r.neg[k] = v[k][DATA_WIDTH-1];
            r.mag[k] = v[k][DATA_WIDTH-1] ? word_t'(-v[k]) : v[k];
        end
        return r;
    endfunction

    always_comb
    begin
        adv[1]   = !vld_reg[1] || out_ready;
        adv[0]   = !vld_reg[0] || adv[1];
        in_ready = adv[0];
    end

    always_comb
    begin
        sq_next.lin = make_vec(in_data.lin);
        sq_next.ang = make_vec(in_data.ang);
        for (int k = 0; k < 3; k++)
        begin
            sq_next.lin_sq[k] = {{DATA_WIDTH{1'b0}}, sq_next.lin.mag[k]}
                              * {{DATA_WIDTH{1'b0}}, sq_next.lin.mag[k]};
            sq_next.ang_sq[k] = {{DATA_WIDTH{1'b0}}, sq_next.ang.mag[k]}
                              * {{DATA_WIDTH{1'b0}}, sq_next.ang.mag[k]};
        end
        sum_next.lin     = sq_reg.lin;
        sum_next.ang     = sq_reg.ang;
        sum_next.lin_sum = sq_reg.lin_sq[0] + sq_reg.lin_sq[1] + sq_reg.lin_sq[2];
        sum_next.ang_sum = sq_reg.ang_sq[0] + sq_reg.ang_sq[1] + sq_reg.ang_sq[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sq_reg <= sq_next;
        end
        if (adv[1])
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign out_data  = sum_reg;

endmodule

FILE: design/tml_sqrt.sv
// Square root pipeline: one root bit per stage for both halves.
module tml_sqrt import tml_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  sum_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output norm_t out_data
);

    logic [SQRT_STEPS-1:0] vld_reg;
    logic [SQRT_STEPS-1:0] adv;
    sqrt_stage_t           stg_reg  [SQRT_STEPS];
    sqrt_stage_t           stg_next [SQRT_STEPS];
    sqrt_stage_t           head;

    always_comb
    begin
        adv[SQRT_STEPS-1] = !vld_reg[SQRT_STEPS-1] || out_ready;
        for (int i = SQRT_STEPS - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        in_ready = adv[0];
    end

    always_comb
    begin
        head.lin   = in_data.lin;
        head.ang   = in_data.ang;
        head.lin_s = '{rad: in_data.lin_sum, rem: '0, root: '0};
        head.ang_s = '{rad: in_data.ang_sum, rem: '0, root: '0};
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            stg_next[i]       = (i == 0) ? head : stg_reg[(i == 0) ? 0 : i - 1];
            stg_next[i].lin_s = sqrt_step(stg_next[i].lin_s);
            stg_next[i].ang_s = sqrt_step(stg_next[i].ang_s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < SQRT_STEPS; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            if (adv[i])
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    assign out_valid         = vld_reg[SQRT_STEPS-1];
    assign out_data.lin      = stg_reg[SQRT_STEPS-1].lin;
    assign out_data.ang      = stg_reg[SQRT_STEPS-1].ang;
    assign out_data.lin_norm = stg_reg[SQRT_STEPS-1].lin_s.root;
    assign out_data.ang_norm = stg_reg[SQRT_STEPS-1].ang_s.root;

endmodule

FILE: design/tml_div.sv
// Scaling pipeline: limit compare and products, restoring division, sign restore.
module tml_div import tml_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  norm_t in_data,
    input  word_t lin_limit,
    input  word_t ang_limit,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_data
);

    localparam int NSTG = DIV_STEPS + 2;

    logic [NSTG-1:0]       vld_reg;
    logic [NSTG-1:0]       adv;
    div_stage_t            stg_reg  [DIV_STEPS+1];
    div_stage_t            stg_next [DIV_STEPS+1];
    res_t                  res_reg;
    res_t                  res_next;
    logic [2:0][SUM_W-1:0] lin_prod;
    logic [2:0][SUM_W-1:0] ang_prod;

    function automatic word_t pick(logic lim, logic neg, word_t mag, word_t q);
        word_t v;
        v = lim ? q : mag;
        return neg ? word_t'(-v) : v;
    endfunction

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        in_ready = adv[0];
    end

    always_comb
    begin
        // Product stage: mag * limit, high word seeds the remainder
        stg_next[0].lin      = in_data.lin;
        stg_next[0].ang      = in_data.ang;
        stg_next[0].lin_norm = in_data.lin_norm;
        stg_next[0].ang_norm = in_data.ang_norm;
        stg_next[0].lin_lim  = in_data.lin_norm > lin_limit;
        stg_next[0].ang_lim  = in_data.ang_norm > ang_limit;
        for (int k = 0; k < 3; k++)
        begin
            lin_prod[k] = {{DATA_WIDTH{1'b0}}, in_data.lin.mag[k]}
                        * {{DATA_WIDTH{1'b0}}, lin_limit};
            ang_prod[k] = {{DATA_WIDTH{1'b0}}, in_data.ang.mag[k]}
                        * {{DATA_WIDTH{1'b0}}, ang_limit};
            stg_next[0].lin_d[k] = '{lo: lin_prod[k][DATA_WIDTH-1:0],
                                     rem: lin_prod[k][SUM_W-1:DATA_WIDTH], q: '0};
            stg_next[0].ang_d[k] = '{lo: ang_prod[k][DATA_WIDTH-1:0],
                                     rem: ang_prod[k][SUM_W-1:DATA_WIDTH], q: '0};
        end
        for (int i = 1; i <= DIV_STEPS; i++)
        begin
            stg_next[i] = stg_reg[i-1];
            for (int k = 0; k < 3; k++)
            begin
                stg_next[i].lin_d[k] = div_step(stg_reg[i-1].lin_d[k], stg_reg[i-1].lin_norm);
                stg_next[i].ang_d[k] = div_step(stg_reg[i-1].ang_d[k], stg_reg[i-1].ang_norm);
            end
        end
        res_next.lin_lim = stg_reg[DIV_STEPS].lin_lim;
        res_next.ang_lim = stg_reg[DIV_STEPS].ang_lim;
        for (int k = 0; k < 3; k++)
        begin
            res_next.lin[k] = pick(stg_reg[DIV_STEPS].lin_lim, stg_reg[DIV_STEPS].lin.neg[k],
                                   stg_reg[DIV_STEPS].lin.mag[k],
                                   stg_reg[DIV_STEPS].lin_d[k].q);
            res_next.ang[k] = pick(stg_reg[DIV_STEPS].ang_lim, stg_reg[DIV_STEPS].ang.neg[k],
                                   stg_reg[DIV_STEPS].ang.mag[k],
                                   stg_reg[DIV_STEPS].ang_d[k].q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DIV_STEPS; i++)
        begin
            if (adv[i])
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
        if (adv[NSTG-1])
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = res_reg;

endmodule

FILE: design/twist_magnitude_limiter_top.sv
// Top level of the twist magnitude limiter: APB limit registers and the pipeline.
// Stages from an accepted command word to its result word:
//   2 front stages, 32 root stages, 1 product stage, 32 divide stages, 1 output stage.
// Throughput: one word per cycle unless the output stalls; every stage moves on its own
//   valid bit and fills a bubble even while the output word waits; a stall drops nothing.
// Reset: rst_n clears all stage valid bits and sets both limits to 1.0 (65536).
// pready is tied high; a write lands on the access cycle.
module twist_magnitude_limiter_top import tml_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tml_cmd_if.sink            cmd,
    tml_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    word_t lin_limit_reg;
    word_t ang_limit_reg;
    logic  cfg_wr;

    cmd_t  cmd_data;
    logic  front_valid;
    logic  front_ready;
    sum_t  front_data;
    logic  root_valid;
    logic  root_ready;
    norm_t root_data;
    res_t  res_data;

    // APB write on the access cycle; the top address bit picks the register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[PADDR_W-1] == REG_ANG) ? ang_limit_reg : lin_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_limit_reg <= LIMIT_RESET;
            ang_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[PADDR_W-1] == REG_ANG)
            begin
                ang_limit_reg <= pwdata;
            end
            else
            begin
                lin_limit_reg <= pwdata;
            end
        end
    end

    // Pack the command word; index 0 is x.
    assign cmd_data.lin[0] = cmd.lin_x;
    assign cmd_data.lin[1] = cmd.lin_y;
    assign cmd_data.lin[2] = cmd.lin_z;
    assign cmd_data.ang[0] = cmd.ang_x;
    assign cmd_data.ang[1] = cmd.ang_y;
    assign cmd_data.ang[2] = cmd.ang_z;

    // Magnitudes and sums of squares
    tml_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_data   (cmd_data),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // Norm of each half, one bit per stage
    tml_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_data  (root_data)
    );

    // Compare against the limits and scale by limit / norm.
    // Limits are read live: change them only while the pipeline is empty; the block does not enforce this.
    tml_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .in_ready  (root_ready),
        .in_data   (root_data),
        .lin_limit (lin_limit_reg),
        .ang_limit (ang_limit_reg),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (res_data)
    );

    assign rsp.out_lin_x       = res_data.lin[0];
    assign rsp.out_lin_y       = res_data.lin[1];
    assign rsp.out_lin_z       = res_data.lin[2];
    assign rsp.out_ang_x       = res_data.ang[0];
    assign rsp.out_ang_y       = res_data.ang[1];
    assign rsp.out_ang_z       = res_data.ang[2];
    assign rsp.linear_limited  = res_data.lin_lim;
    assign rsp.angular_limited = res_data.ang_lim;

endmodule

FILE: design/tml_checker.sv
// Port-level checker for the twist magnitude limiter, bound to the top level.
`include "twist_magnitude_limiter_top_assert.svh"

module tml_checker import tml_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [DATA_WIDTH-1:0] rsp_lin_x,
    input logic               rsp_lin_flag,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata
);

    // Hold a stalled result word
    `TML_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `TML_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_lin_x) && $stable(rsp_lin_flag))
    // An empty output stage leaves the whole pipeline free to advance
    `TML_ASSERT_NOW(a_ready_when_empty, !rsp_valid, cmd_ready)
    // A linear limit write reads back on the next cycle
    `TML_ASSERT_NEXT(a_lin_readback, psel && penable && pwrite && (paddr[PADDR_W-1] == REG_LIN), (paddr[PADDR_W-1] == REG_ANG) || (prdata == $past(pwdata)))

endmodule

bind twist_magnitude_limiter_top tml_checker u_tml_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_ready    (cmd.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_lin_x    (rsp.out_lin_x),
    .rsp_lin_flag (rsp.linear_limited),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

FILE: tb/twist_magnitude_limiter_top_tb.sv
// Self-checking testbench of the twist magnitude limiter: random commands, limits and stalls.
`timescale 1ns / 100ps

module twist_magnitude_limiter_top_tb import tml_pkg::*;
    ;

    // Register byte addresses: the select bit sits above the word offset.
    localparam logic [PADDR_W-1:0] ADDR_LIN = {REG_LIN, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_ANG = {REG_ANG, 2'b00};
    localparam int LATENCY = 68;
    localparam int PHASE_ITEMS = 290;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    tml_cmd_if cmd ();
    tml_rsp_if rsp ();

    twist_magnitude_limiter_top dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // Testbench copy of the two limit registers.
    word_t lin_limit = LIMIT_RESET;
    word_t ang_limit = LIMIT_RESET;

    cmd_t pending_cmds[$];
    res_t limited_words[$];
    cmd_t next_cmd;
    int errors = 0;

    logic cmd_fire = 1'b0;
    int cmd_gap = 0;
    int rsp_gap = 0;
    int long_left = 0;
    bit no_idle = 1'b0;
    bit stall_go = 1'b0;
    bit stall_done = 1'b0;

    initial
    begin
        cmd.valid = 1'b0;
        cmd.lin_x = '0;
        cmd.lin_y = '0;
        cmd.lin_z = '0;
        cmd.ang_x = '0;
        cmd.ang_y = '0;
        cmd.ang_z = '0;
        rsp.ready = 1'b0;
    end

    // Floor of the square root of a sum of three squares; the root fits in 33 bits.
    function automatic logic [32:0] isqrt(logic [65:0] n);
        logic [32:0] r;
        logic [32:0] t;
        r = '0;
        for (int b = 32; b >= 0; b--)
        begin
            t = r | (33'd1 << b);
            if ({33'd0, t} * {33'd0, t} <= n)
                r = t;
        end
        return r;
    endfunction

    // Saturate one 3-vector to its limit; returns the scaled flag.
    function automatic logic clamp_vector(input word_t in_v [3], input word_t lim,
                                          output word_t out_v [3]);
        logic [32:0] mag [3];
        logic [65:0] sum;
        logic [32:0] norm;
        logic [65:0] q;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            // Take the magnitude exactly, including the most negative value.
            mag[i] = in_v[i][DATA_WIDTH-1] ? 33'(-{1'b1, in_v[i]}) : {1'b0, in_v[i]};
            sum += {33'd0, mag[i]} * {33'd0, mag[i]};
            out_v[i] = in_v[i];
        end
        norm = isqrt(sum);
        // Zero norm and norm equal to the limit both pass unchanged.
        if (norm == 0 || norm <= {1'b0, lim})
            return 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            q = ({33'd0, mag[i]} * {34'd0, lim}) / {33'd0, norm};
            out_v[i] = in_v[i][DATA_WIDTH-1] ? word_t'(-q) : word_t'(q);
        end
        return 1'b1;
    endfunction

    function automatic res_t limit_command(cmd_t c);
        res_t r;
        word_t a [3];
        word_t b [3];
        for (int i = 0; i < 3; i++)
            a[i] = c.lin[i];
        r.lin_lim = clamp_vector(a, lin_limit, b);
        for (int i = 0; i < 3; i++)
            r.lin[i] = b[i];
        for (int i = 0; i < 3; i++)
            a[i] = c.ang[i];
        r.ang_lim = clamp_vector(a, ang_limit, b);
        for (int i = 0; i < 3; i++)
            r.ang[i] = b[i];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Drive the command channel: hold a word until taken, then advance or idle.
    always @(negedge clk)
    begin
        if (rst_n && (!cmd.valid || cmd_fire))
        begin
            if (cmd_gap > 0)
            begin
                cmd.valid <= 1'b0;
                cmd_gap <= cmd_gap - 1;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                cmd.valid <= 1'b0;
                cmd_gap <= $urandom_range(0, 5);
            end
            else if (pending_cmds.size() > 0)
            begin
                next_cmd = pending_cmds.pop_front();
                cmd.valid <= 1'b1;
                cmd.lin_x <= next_cmd.lin[0];
                cmd.lin_y <= next_cmd.lin[1];
                cmd.lin_z <= next_cmd.lin[2];
                cmd.ang_x <= next_cmd.ang[0];
                cmd.ang_y <= next_cmd.ang[1];
                cmd.ang_z <= next_cmd.ang[2];
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // Drive ready: random bursts, plus one long hold-off to back up the pipeline.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (long_left > 0)
        begin
            rsp.ready <= 1'b0;
            long_left <= long_left - 1;
        end
        else if (stall_go && !stall_done)
        begin
            rsp.ready <= 1'b0;
            long_left <= 300;
            stall_done <= 1'b1;
        end
        else if (rsp_gap > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            rsp.ready <= 1'b0;
            rsp_gap <= $urandom_range(0, 5);
        end
        else
            rsp.ready <= 1'b1;
    end

    // Predict on every accepted command word and check every accepted result word.
    always @(posedge clk)
    begin
        res_t want;
        cmd_t c;
        cmd_fire <= cmd.valid && cmd.ready;
        if (rst_n && cmd.valid && cmd.ready)
        begin
            c.lin[0] = cmd.lin_x;
            c.lin[1] = cmd.lin_y;
            c.lin[2] = cmd.lin_z;
            c.ang[0] = cmd.ang_x;
            c.ang[1] = cmd.ang_y;
            c.ang[2] = cmd.ang_z;
            limited_words.push_back(limit_command(c));
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (limited_words.size() == 0)
            begin
                $display("unexpected result word at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = limited_words.pop_front();
                if (rsp.out_lin_x !== want.lin[0]) report("out_lin_x", rsp.out_lin_x, want.lin[0]);
                if (rsp.out_lin_y !== want.lin[1]) report("out_lin_y", rsp.out_lin_y, want.lin[1]);
                if (rsp.out_lin_z !== want.lin[2]) report("out_lin_z", rsp.out_lin_z, want.lin[2]);
                if (rsp.out_ang_x !== want.ang[0]) report("out_ang_x", rsp.out_ang_x, want.ang[0]);
                if (rsp.out_ang_y !== want.ang[1]) report("out_ang_y", rsp.out_ang_y, want.ang[1]);
                if (rsp.out_ang_z !== want.ang[2]) report("out_ang_z", rsp.out_ang_z, want.ang[2]);
                if (rsp.linear_limited !== want.lin_lim)
                    report("linear_limited", 32'(rsp.linear_limited), 32'(want.lin_lim));
                if (rsp.angular_limited !== want.ang_lim)
                    report("angular_limited", 32'(rsp.angular_limited), 32'(want.ang_lim));
            end
        end
    end

    // Setup cycle, then access cycle; the register lands at the access edge.
    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_limits(word_t lin, word_t ang);
        apb_write(ADDR_LIN, lin);
        apb_write(ADDR_ANG, ang);
        lin_limit = lin;
        ang_limit = ang;
    endtask

    function automatic word_t rand_component(int mode);
        case (mode)
            0: return $urandom;
            1: return word_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default:
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return 32'h8000_0000;
                    2: return 32'h7fff_ffff;
                    3: return 32'hffff_ffff;
                    default: return 32'd1;
                endcase
        endcase
    endfunction

    task automatic queue_cmd(word_t lx, word_t ly, word_t lz, word_t ax, word_t ay, word_t az);
        cmd_t c;
        c.lin[0] = lx;
        c.lin[1] = ly;
        c.lin[2] = lz;
        c.ang[0] = ax;
        c.ang[1] = ay;
        c.ang[2] = az;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_random(int count);
        int mode;
        for (int n = 0; n < count; n++)
        begin
            // Half the commands use components near the limits so both branches show up.
            mode = $urandom_range(0, 9) < 5 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0);
            queue_cmd(rand_component(mode), rand_component(mode), rand_component(mode),
                      rand_component(mode), rand_component(mode), rand_component(mode));
        end
    endtask

    // Drain everything in flight, then let the pipeline go quiet.
    task automatic drain();
        while (pending_cmds.size() > 0 || cmd.valid || limited_words.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset limits of 1.0: zero, extremes, norm equal to the limit, just above.
        queue_cmd(0, 0, 0, 0, 0, 0);
        queue_cmd(32'h0001_0000, 0, 0, 0, 32'hffff_0000, 0);
        queue_cmd(32'h0001_0001, 0, 0, 0, 0, 32'hfffe_ffff);
        queue_cmd(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_cmd(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 1);
        queue_cmd(1, 32'hffff_ffff, 1, 32'hffff_ffff, 1, 32'hffff_ffff);
        queue_cmd(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0, 32'h0000_b505, 32'h0000_b505);
        queue_random(PHASE_ITEMS);
        stall_go = 1'b1;
        drain();

        // Zero limits: every nonzero half collapses to zeros.
        set_limits(0, 0);
        queue_cmd(0, 0, 0, 32'h8000_0000, 0, 0);
        queue_cmd(1, 0, 0, 0, 0, 0);
        queue_random(PHASE_ITEMS);
        drain();

        // Largest limits.
        set_limits(32'hffff_ffff, 32'hffff_ffff);
        queue_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_random(PHASE_ITEMS);
        drain();

        set_limits(1, 32'h0003_0000);
        queue_random(PHASE_ITEMS);
        drain();

        set_limits($urandom_range(0, 1 << 20), $urandom);
        queue_random(PHASE_ITEMS);
        drain();

        // Final stretch with no idling on either side.
        set_limits($urandom, $urandom_range(0, 1 << 19));
        no_idle = 1'b1;
        queue_random(PHASE_ITEMS);
        drain();

        if (errors == 0)
            $display("** twist_magnitude_limiter_top: PASSED **");
        else
            $display("** twist_magnitude_limiter_top: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout at %0t", $realtime);
        $display("** twist_magnitude_limiter_top: FAILED **");
        $finish;
    end

endmodule
